### rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BF7_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BF7_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/bf7_pkg.sv
`timescale 1ns / 1ps
package bf7_pkg;
   localparam int TABLE_DEPTH_DEF = 16384;
   localparam int KEY_BITS_DEF    = 15;
   localparam int CFG_BITS        = 15;
   localparam int KEY_PORT_BITS   = 15;
   localparam logic [CFG_BITS-1:0] SIZE_RESET = 15'd257;
   localparam int SIZE_MIN        = 2;
   localparam int HASH_MUL        = 7;
   localparam int HASH_OFFSET     = 64;
   localparam int FOLD_SHIFT      = 4;
   localparam int SHIFT_LEFT      = 5;
   localparam int SHIFT_RIGHT     = 2;
   localparam int LAST_JOB        = 6;
   localparam int JOB_POWER       = 3;

   typedef enum logic {
      KIND_ADD    = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;
endpackage

### rtl/bf7_ram.sv
`timescale 1ns / 1ps
module bf7_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = bf7_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### rtl/bloom_filter_seven_hash_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall req_kind, req_key
// rsp_      out        rsp_valid/rsp_stall rsp_maybe_present
// csr_      in         csr_valid/csr_ready csr_table_size
//
// Each hash is reduced by one shared restoring remainder unit, one dividend bit per
// cycle, after a load step; the power hash of a zero key skips the reduction.
// One transaction runs 6 + (1 + bitlen(key) + popcount(key)) reductions, or 6 for a
// zero key, plus table access; only a search returns.
// After reset the table is swept to zero with req_stall high.
// A finished search result waits in the output register while rsp_stall is high.
`include "assert_macros.svh"
module bloom_filter_seven_hash_top #(
   parameter int TABLE_DEPTH = bf7_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = bf7_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [bf7_pkg::KEY_PORT_BITS-1:0]  req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_maybe_present,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bf7_pkg::CFG_BITS-1:0]       csr_table_size
);
   // modulus, table address, multiplier, dividend and config compare widths
   localparam int MW   = $clog2(TABLE_DEPTH + 1);
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int MULW = (MW > KEY_BITS) ? MW : KEY_BITS;
   localparam int DW   = 2 * MULW + 1;
   localparam int CW   = (MW > bf7_pkg::CFG_BITS) ? MW : bf7_pkg::CFG_BITS;
   localparam int CNTW = $clog2(DW);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SQUARE, ST_LOAD, ST_MOD,
      ST_PW_STEP, ST_PW_MUL, ST_ACCESS, ST_CHECK, ST_DONE
   } state_type;

   // what the running reduction produces
   typedef enum logic [1:0] {
      PH_POS, PH_BASE_INIT, PH_RES, PH_BASE
   } phase_type;

   state_type                 state_ff;
   phase_type                 ph_ff;
   logic [bf7_pkg::CFG_BITS-1:0] size_ff;
   logic [AW-1:0]             clr_ff;
   logic [KEY_BITS-1:0]       key_ff;
   bf7_pkg::kind_type         kind_ff;
   logic [MW-1:0]             m_ff;
   logic [2*KEY_BITS-1:0]     sq_ff;
   logic [DW-1:0]             div_ff;
   logic [MW-1:0]             rem_ff;
   logic [CNTW-1:0]           cnt_ff;
   logic [MW-1:0]             res_ff;
   logic [MW-1:0]             base_ff;
   logic [KEY_BITS-1:0]       exp_ff;
   logic [AW-1:0]             pos_ff;
   logic [2:0]                job_ff;
   logic                      hit_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;

   logic [CW-1:0]             size_ext;
   logic [MW-1:0]             m_in;
   logic [MULW-1:0]           mul_a;
   logic [MULW-1:0]           mul_b;
   logic [2*MULW-1:0]         mul_p;
   logic [MW:0]               rem_sh;
   logic [MW-1:0]             rem_in;
   logic [DW-1:0]             load_div;
   logic                      last_job;
   logic                      out_free;
   logic                      ram_we;
   logic [AW-1:0]             ram_wa;
   logic                      ram_wd;
   logic                      ram_re;
   logic                      ram_rd;

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_hit_ff;

   // clamp the configured size into [2, TABLE_DEPTH]
   always_comb begin
      size_ext = CW'(size_ff);
      if (size_ext < CW'(bf7_pkg::SIZE_MIN)) begin
         m_in = MW'(bf7_pkg::SIZE_MIN);
      end else if (size_ext > CW'(TABLE_DEPTH)) begin
         m_in = MW'(TABLE_DEPTH);
      end else begin
         m_in = MW'(size_ext);
      end
   end

   // shared multiplier: key squaring, then power products
   always_comb begin
      if (state_ff == ST_SQUARE) begin
         mul_a = MULW'(key_ff);
         mul_b = MULW'(key_ff);
      end else begin
         mul_a = (ph_ff == PH_RES) ? MULW'(res_ff) : MULW'(base_ff);
         mul_b = MULW'(base_ff);
      end
   end
   assign mul_p = mul_a * mul_b;

   // one restoring remainder step
   assign rem_sh = {rem_ff, div_ff[DW-1]};
   assign rem_in = (rem_sh >= {1'b0, m_ff}) ? MW'(rem_sh - {1'b0, m_ff}) : MW'(rem_sh);

   // dividend of each hash position
   always_comb begin
      unique case (job_ff)
         3'd0: load_div = DW'(sq_ff);
         3'd1: load_div = DW'(sq_ff) + DW'(key_ff) * DW'(bf7_pkg::HASH_MUL)
                          + DW'(bf7_pkg::HASH_OFFSET);
         3'd4: load_div = DW'(key_ff ^ (key_ff >> bf7_pkg::FOLD_SHIFT));
         3'd5: load_div = DW'(sq_ff) ^ DW'(key_ff);
         3'd6: load_div = (DW'(key_ff) << bf7_pkg::SHIFT_LEFT)
                          ^ DW'(key_ff >> bf7_pkg::SHIFT_RIGHT);
         default: load_div = DW'(key_ff);
      endcase
   end

   assign last_job = (job_ff == 3'(bf7_pkg::LAST_JOB));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // table port: clearing sweep, add writes, search reads
   assign ram_we = (state_ff == ST_CLEAR)
                   || (state_ff == ST_ACCESS && kind_ff == bf7_pkg::KIND_ADD);
   assign ram_wa = (state_ff == ST_CLEAR) ? clr_ff : pos_ff;
   assign ram_wd = (state_ff != ST_CLEAR);
   assign ram_re = (state_ff == ST_ACCESS && kind_ff == bf7_pkg::KIND_SEARCH);

   bf7_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= bf7_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_table_size;
         end
         // drop the result once the consumer takes it
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  key_ff   <= req_key[KEY_BITS-1:0];
                  kind_ff  <= bf7_pkg::kind_type'(req_kind);
                  m_ff     <= m_in;
                  job_ff   <= '0;
                  hit_ff   <= 1'b1;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               sq_ff    <= (2*KEY_BITS)'(mul_p);
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rem_ff <= '0;
               cnt_ff <= CNTW'(DW - 1);
               div_ff <= load_div;
               if (job_ff == 3'(bf7_pkg::JOB_POWER)) begin
                  if (key_ff == '0) begin
                     // zero key: power position is zero
                     pos_ff   <= '0;
                     state_ff <= ST_ACCESS;
                  end else begin
                     ph_ff    <= PH_BASE_INIT;
                     state_ff <= ST_MOD;
                  end
               end else begin
                  ph_ff    <= PH_POS;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               rem_ff <= rem_in;
               div_ff <= {div_ff[DW-2:0], 1'b0};
               cnt_ff <= cnt_ff - CNTW'(1);
               if (cnt_ff == '0) begin
                  unique case (ph_ff)
                     PH_POS: begin
                        pos_ff   <= AW'(rem_in);
                        state_ff <= ST_ACCESS;
                     end
                     PH_BASE_INIT: begin
                        base_ff  <= rem_in;
                        res_ff   <= MW'(1);
                        exp_ff   <= key_ff;
                        state_ff <= ST_PW_STEP;
                     end
                     PH_RES: begin
                        res_ff   <= rem_in;
                        ph_ff    <= PH_BASE;
                        state_ff <= ST_PW_MUL;
                     end
                     PH_BASE: begin
                        base_ff  <= rem_in;
                        exp_ff   <= exp_ff >> 1;
                        state_ff <= ST_PW_STEP;
                     end
                  endcase
               end
            end
            ST_PW_STEP: begin
               if (exp_ff == '0) begin
                  pos_ff   <= AW'(res_ff);
                  state_ff <= ST_ACCESS;
               end else begin
                  ph_ff    <= exp_ff[0] ? PH_RES : PH_BASE;
                  state_ff <= ST_PW_MUL;
               end
            end
            ST_PW_MUL: begin
               // register the product as the next dividend
               div_ff   <= DW'(mul_p);
               rem_ff   <= '0;
               cnt_ff   <= CNTW'(DW - 1);
               state_ff <= ST_MOD;
            end
            ST_ACCESS: begin
               if (kind_ff == bf7_pkg::KIND_SEARCH) begin
                  state_ff <= ST_CHECK;
               end else if (last_job) begin
                  state_ff <= ST_IDLE;
               end else begin
                  job_ff   <= job_ff + 3'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_CHECK: begin
               hit_ff <= hit_ff & ram_rd;
               if (last_job) begin
                  state_ff <= ST_DONE;
               end else begin
                  job_ff   <= job_ff + 3'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `BF7_ASSERT_IMPL(a_rem_bound, clock, reset, state_ff == ST_MOD, rem_ff < m_ff)
   `BF7_ASSERT_IMPL(a_pos_bound, clock, reset, state_ff == ST_ACCESS, MW'(pos_ff) < m_ff)
   `BF7_ASSERT_NEXT(a_accept_start, clock, reset, req_valid && !req_stall, state_ff == ST_SQUARE)
endmodule
